[rtl/i2r_pkg.sv]
// Package for the integer to radix digits converter.
// Holds shared widths, register indexes, reset values and the symbol lookup.
// No dependencies.
`default_nettype none

package i2r_pkg;

    localparam int VALUE_WIDTH_DEF = 64;
    localparam int MAX_RADIX_DEF   = 16;

    localparam int RADIX_W       = 5;
    localparam int SYM_W         = 8;
    localparam int SYMBOLS_W     = 64;
    localparam int SYM_DIGIT_W   = 4;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_RADIX        = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

    localparam logic [RADIX_W-1:0]   RADIX_RESET        = 5'd10;
    localparam logic [SYMBOLS_W-1:0] SYMBOLS_LOW_RESET  = 64'h3736353433323130;
    localparam logic [SYMBOLS_W-1:0] SYMBOLS_HIGH_RESET = 64'h6665646362613938;

    typedef struct packed {
        logic done;
        logic last;
    } div_status_t;

    function automatic logic [SYM_W-1:0] sym_of(
        input logic [SYM_DIGIT_W-1:0] digit,
        input logic [SYMBOLS_W-1:0]   lo,
        input logic [SYMBOLS_W-1:0]   hi
    );
        logic [SYMBOLS_W-1:0] word;
        word = digit[3] ? hi : lo;
        return word[digit[2:0]*SYM_W +: SYM_W];
    endfunction

endpackage

`default_nettype wire

[rtl/i2r_divider.sv]
// Bit-serial restoring divider that peels off one digit per pass.
// Depends on i2r_pkg.
`default_nettype none

module i2r_divider
    import i2r_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int MAX_RADIX   = MAX_RADIX_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         load,
    input  wire logic [VALUE_WIDTH-1:0]       value,
    input  wire logic [RADIX_W-1:0]           radix,
    output logic [$clog2(MAX_RADIX)-1:0]      digit,
    output div_status_t                       status
);

    localparam int DW = $clog2(MAX_RADIX);
    localparam int BW = $clog2(VALUE_WIDTH);
    localparam int TW = RADIX_W + 1;

    logic [VALUE_WIDTH-1:0] quo_reg, quo_next;
    logic [DW-1:0]          rem_reg, rem_next;
    logic [BW-1:0]          bit_reg, bit_next;
    logic                   nz_reg, nz_next;
    logic                   run_reg, run_next;

    logic [DW:0]            trial;
    logic                   qbit;
    logic                   last_bit;
    logic [DW-1:0]          rem_step;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[VALUE_WIDTH-1]};
        qbit     = TW'(trial) >= TW'(radix);
        rem_step = qbit ? DW'(TW'(trial) - TW'(radix)) : DW'(trial);
        last_bit = bit_reg == BW'(VALUE_WIDTH - 1);

        digit       = rem_step;
        status.done = run_reg & last_bit;
        status.last = ~(nz_reg | qbit);

        quo_next = quo_reg;
        rem_next = rem_reg;
        bit_next = bit_reg;
        nz_next  = nz_reg;
        run_next = run_reg;

        if (load)
        begin
            quo_next = value;
            rem_next = '0;
            bit_next = '0;
            nz_next  = 1'b0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            quo_next = {quo_reg[VALUE_WIDTH-2:0], qbit};
            if (last_bit)
            begin
                rem_next = '0;
                bit_next = '0;
                nz_next  = 1'b0;
                run_next = ~status.last;
            end
            else
            begin
                rem_next = rem_step;
                bit_next = bit_reg + BW'(1);
                nz_next  = nz_reg | qbit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            bit_reg <= '0;
            nz_reg  <= 1'b0;
            rem_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            bit_reg <= bit_next;
            nz_reg  <= nz_next;
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
    end

endmodule

`default_nettype wire

[rtl/i2r_digit_stack.sv]
// Digit store that keeps remainders until they are read back in reverse order.
// One write port and one registered read port. Depends on i2r_pkg.
`default_nettype none

module i2r_digit_stack
    import i2r_pkg::*;
#(
    parameter int DEPTH = VALUE_WIDTH_DEF,
    parameter int DW    = $clog2(MAX_RADIX_DEF)
)
(
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [DW-1:0]            wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DW-1:0]                 rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/integer_to_radix_digits_core.sv]
// Converts an unsigned value to radix digit symbols, most significant first.
// Each digit is produced by the bit-serial divider and pushed onto the digit stack; once the
// quotient is zero the digits are read back in reverse order, and busy stays high until the
// last one has been read. Read digits pass a registered symbol lookup and are strobed one per cycle.
// A new start is accepted only while idle; the receiver cannot stall.
// Reset (rst_n low, asynchronous) restores radix 10 and the "0-9a-f" alphabet.
`default_nettype none

module integer_to_radix_digits_core
    import i2r_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int MAX_RADIX   = MAX_RADIX_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic [VALUE_WIDTH-1:0] value,
    input  wire logic                   wr_en,
    input  wire logic [CFG_INDEX_W-1:0] wr_index,
    input  wire logic [CFG_DATA_W-1:0]  wr_data,
    output logic                        strobe,
    output logic [SYM_W-1:0]            symbol,
    output logic                        last_digit
);

    localparam int DW = $clog2(MAX_RADIX);
    localparam int AW = $clog2(VALUE_WIDTH);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_DIVIDE = 3'b010,
        ST_EMIT   = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [RADIX_W-1:0]   radix_reg;
    logic [SYMBOLS_W-1:0] sym_lo_reg;
    logic [SYMBOLS_W-1:0] sym_hi_reg;
    logic [RADIX_W-1:0]   eff_radix;

    logic [AW-1:0]        count_reg, count_next;
    logic [AW-1:0]        rd_ptr_reg, rd_ptr_next;
    logic                 rd_valid_reg, rd_valid_next;
    logic                 rd_last_reg, rd_last_next;
    logic                 strobe_reg;
    logic                 last_reg;
    logic [SYM_W-1:0]     symbol_reg;

    logic                 load;
    logic                 re;
    logic [DW-1:0]        digit;
    logic [DW-1:0]        rdata;
    div_status_t          div_status;

    always_comb
    begin
        if (radix_reg < RADIX_W'(2))
        begin
            eff_radix = RADIX_W'(2);
        end
        else if (radix_reg > RADIX_W'(MAX_RADIX))
        begin
            eff_radix = RADIX_W'(MAX_RADIX);
        end
        else
        begin
            eff_radix = radix_reg;
        end
    end

    i2r_divider #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_RADIX   (MAX_RADIX)
    ) u_divider (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (load),
        .value  (value),
        .radix  (eff_radix),
        .digit  (digit),
        .status (div_status)
    );

    i2r_digit_stack #(
        .DEPTH (VALUE_WIDTH),
        .DW    (DW)
    ) u_stack (
        .clk   (clk),
        .we    (div_status.done),
        .waddr (count_reg),
        .wdata (digit),
        .re    (re),
        .raddr (rd_ptr_reg),
        .rdata (rdata)
    );

    assign busy = state_reg != ST_IDLE;
    assign load = start & ~busy;

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        rd_ptr_next   = rd_ptr_reg;
        rd_valid_next = 1'b0;
        rd_last_next  = 1'b0;
        re            = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    count_next = '0;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (div_status.done)
                begin
                    count_next = count_reg + AW'(1);
                    if (div_status.last)
                    begin
                        rd_ptr_next = count_reg;
                        state_next  = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                re            = 1'b1;
                rd_valid_next = 1'b1;
                rd_last_next  = rd_ptr_reg == '0;
                rd_ptr_next   = rd_ptr_reg - AW'(1);
                if (rd_ptr_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            rd_ptr_reg   <= '0;
            rd_valid_reg <= 1'b0;
            rd_last_reg  <= 1'b0;
            strobe_reg   <= 1'b0;
            last_reg     <= 1'b0;
            radix_reg    <= RADIX_RESET;
            sym_lo_reg   <= SYMBOLS_LOW_RESET;
            sym_hi_reg   <= SYMBOLS_HIGH_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            rd_ptr_reg   <= rd_ptr_next;
            rd_valid_reg <= rd_valid_next;
            rd_last_reg  <= rd_last_next;
            strobe_reg   <= rd_valid_reg;
            last_reg     <= rd_last_reg;
            if (wr_en)
            begin
                case (wr_index)
                    REG_RADIX:        radix_reg  <= wr_data[RADIX_W-1:0];
                    REG_SYMBOLS_LOW:  sym_lo_reg <= wr_data[SYMBOLS_W-1:0];
                    REG_SYMBOLS_HIGH: sym_hi_reg <= wr_data[SYMBOLS_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        symbol_reg <= sym_of(SYM_DIGIT_W'(rdata), sym_lo_reg, sym_hi_reg);
    end

    assign strobe     = strobe_reg;
    assign symbol     = symbol_reg;
    assign last_digit = last_reg & strobe_reg;

endmodule

`default_nettype wire

[rtl/i2r_checker.sv]
// Port-level checks for the integer to radix digits converter, bound to the top level.
// Depends on i2r_pkg and integer_to_radix_digits_core.
`default_nettype none

module i2r_checker
    import i2r_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic strobe,
    input wire logic last_digit
);

    // An accepted start keeps the core busy on the next cycle.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("core not busy after an accepted start");

    // The final symbol transfer follows the end of the busy period.
    a_last_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> ##1 (strobe && last_digit))
        else $error("missing final symbol after busy fell");

    // Symbols of one number arrive on consecutive cycles.
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last_digit |=> strobe)
        else $error("gap inside a symbol sequence");

    // A final symbol is never followed directly by another symbol.
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last_digit |=> !strobe)
        else $error("symbol right after a final symbol");

endmodule

bind integer_to_radix_digits_core i2r_checker u_i2r_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .strobe     (strobe),
    .last_digit (last_digit)
);

`default_nettype wire

[tb/integer_to_radix_digits_core_test.sv]
// Self-checking testbench for integer_to_radix_digits_core: drives values and
// register writes, predicts every digit symbol and checks each strobed result.
// Depends on i2r_pkg and the integer_to_radix_digits_core RTL.
`timescale 1ns / 1ps

module integer_to_radix_digits_core_test
    import i2r_pkg::*;
();

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 64 * (VALUE_WIDTH_DEF + 1) + 16;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS = 51;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
    } digit_t;

    class digit_checker;
        logic [RADIX_W-1:0]   radix_reg;
        logic [SYMBOLS_W-1:0] sym_lo;
        logic [SYMBOLS_W-1:0] sym_hi;
        digit_t               expected_digits[$];
        int                   mismatches;
        int                   checked;
        int                   values;

        function new();
            radix_reg   = RADIX_RESET;
            sym_lo      = SYMBOLS_LOW_RESET;
            sym_hi      = SYMBOLS_HIGH_RESET;
            mismatches  = 0;
            checked     = 0;
            values      = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                REG_RADIX:        radix_reg = data[RADIX_W-1:0];
                REG_SYMBOLS_LOW:  sym_lo = data;
                REG_SYMBOLS_HIGH: sym_hi = data;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_digits.size();
        endfunction

        function void note_value(logic [63:0] v);
            logic [63:0]          base;
            logic [63:0]          rest;
            logic [3:0]           digits[64];
            logic [SYMBOLS_W-1:0] word;
            digit_t               d;
            int                   n;
            base = 64'(radix_reg);
            if (base < 2)
                base = 2;
            if (base > MAX_RADIX_DEF)
                base = MAX_RADIX_DEF;
            rest = v;
            n = 0;
            do begin
                digits[n] = 4'(rest % base);
                rest = rest / base;
                n++;
            end while (rest != 0 && n < 64);
            for (int k = n - 1; k >= 0; k--) begin
                word = digits[k][3] ? sym_hi : sym_lo;
                d.symbol = word[digits[k][2:0]*SYM_W +: SYM_W];
                d.last = (k == 0);
                expected_digits.push_back(d);
            end
            values++;
        endfunction

        function void check_symbol(logic [SYM_W-1:0] symbol, logic last);
            digit_t want;
            if (expected_digits.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected digit: symbol %02h last %0b", symbol, last);
                return;
            end
            want = expected_digits.pop_front();
            checked++;
            if (want.symbol !== symbol || want.last !== last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Digit mismatch: expected symbol %02h last %0b, got %02h last %0b",
                             want.symbol, want.last, symbol, last);
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic [63:0]            value;
    logic                   wr_en;
    logic [CFG_INDEX_W-1:0] wr_index;
    logic [CFG_DATA_W-1:0]  wr_data;
    logic                   strobe;
    logic [SYM_W-1:0]       symbol;
    logic                   last_digit;

    digit_checker board;
    int           settings;

    integer_to_radix_digits_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .value      (value),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .strobe     (strobe),
        .symbol     (symbol),
        .last_digit (last_digit)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #80000000;
        $display("TB_ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && strobe)
            board.check_symbol(symbol, last_digit);
    end

    task automatic send_value(input logic [63:0] v);
        start <= 1'b1;
        value <= v;
        do
            @(posedge clk);
        while (busy);
        board.note_value(v);
    endtask

    task automatic idle_burst();
        start <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
    endtask

    task automatic settle();
        start <= 1'b0;
        while (board.pending() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_config(input logic [RADIX_W-1:0] r, input logic [63:0] lo,
                               input logic [63:0] hi);
        logic [CFG_DATA_W-1:0] radix_word;
        logic [CFG_DATA_W-1:0] junk;
        radix_word = {$urandom, $urandom};
        radix_word[RADIX_W-1:0] = r;
        junk = {$urandom, $urandom};
        wr_en <= 1'b1;
        wr_index <= REG_RADIX;
        wr_data <= radix_word;
        @(posedge clk);
        board.set_reg(REG_RADIX, radix_word);
        wr_index <= REG_SYMBOLS_LOW;
        wr_data <= lo;
        @(posedge clk);
        board.set_reg(REG_SYMBOLS_LOW, lo);
        wr_index <= REG_SYMBOLS_HIGH;
        wr_data <= hi;
        @(posedge clk);
        board.set_reg(REG_SYMBOLS_HIGH, hi);
        wr_index <= REG_UNUSED;
        wr_data <= junk;
        @(posedge clk);
        board.set_reg(REG_UNUSED, junk);
        wr_en <= 1'b0;
        @(posedge clk);
        settings++;
    endtask

    function automatic logic [63:0] random_value();
        logic [63:0] v;
        int          len;
        v = {$urandom, $urandom};
        if ($urandom_range(0, 3) == 0)
            return v;
        len = $urandom_range(0, 16);
        return (len == 0) ? 64'd0 : (v & ((64'd1 << len) - 64'd1));
    endfunction

    function automatic logic [RADIX_W-1:0] random_radix();
        case ($urandom_range(0, 5))
            0: return 5'd2;
            1: return 5'd16;
            2: return 5'($urandom_range(0, 31));
            3: return 5'd10;
            4: return 5'($urandom_range(2, 16));
            default: return ($urandom_range(0, 1) == 0) ? 5'($urandom_range(0, 1))
                                                         : 5'($urandom_range(17, 31));
        endcase
    endfunction

    function automatic logic [63:0] random_symbols();
        case ($urandom_range(0, 7))
            0: return 64'd0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial
    begin
        int          waited;
        logic [4:0]  r;
        start = 1'b0;
        value = '0;
        wr_en = 1'b0;
        wr_index = '0;
        wr_data = '0;
        rst_n = 1'b0;
        settings = 1;
        board = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        send_value(64'd0);
        send_value(64'd1);
        send_value(64'd9);
        send_value(64'd10);
        send_value('1);
        send_value(64'h8000_0000_0000_0000);
        send_value(64'd12345678901234567890);
        settle();
        load_config(5'd2, {$urandom, $urandom}, {$urandom, $urandom});
        send_value(64'd0);
        send_value(64'd1);
        send_value('1);
        send_value(64'h8000_0000_0000_0000);
        settle();
        load_config(5'd16, {$urandom, $urandom}, {$urandom, $urandom});
        send_value('1);
        send_value(64'd15);
        send_value(64'd16);
        settle();
        load_config(5'd0, 64'd0, '1);
        send_value(64'd5);
        send_value(64'd0);
        settle();
        load_config(5'd1, '1, 64'd0);
        send_value(64'd6);
        settle();
        load_config(5'd31, {$urandom, $urandom}, {$urandom, $urandom});
        send_value(64'd255);
        send_value(64'hFEDC_BA98_7654_3210);
        settle();
        load_config(5'd17, SYMBOLS_LOW_RESET, SYMBOLS_HIGH_RESET);
        send_value(64'hFFFF);
        settle();
        load_config(5'd3, {$urandom, $urandom}, {$urandom, $urandom});
        send_value('1);
        settle();
        load_config(5'd7, {$urandom, $urandom}, {$urandom, $urandom});
        send_value(64'd48);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            settle();
            r = (p == 0) ? 5'd2 : (p == 1) ? 5'd16 : random_radix();
            load_config(r, random_symbols(), random_symbols());
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == 3 && i == 25)
                    settle();
                else if (p < RANDOM_PHASES - 1 && $urandom_range(0, 3) == 0)
                    idle_burst();
                send_value(random_value());
            end
        end

        start <= 1'b0;
        waited = 0;
        while (board.pending() != 0 && waited < 20 * DRAIN_CYCLES) begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Converted %0d values into %0d checked digits under %0d register settings.",
                 board.values, board.checked, settings);
        $display("Radix values from 0 to 31 and extreme alphabets were exercised.");
        if (board.pending() != 0)
            $display("%0d expected digits never arrived.", board.pending());
        if (board.mismatches == 0 && board.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[filelist.f]
rtl/i2r_pkg.sv
rtl/i2r_divider.sv
rtl/i2r_digit_stack.sv
rtl/integer_to_radix_digits_core.sv
rtl/i2r_checker.sv
tb/integer_to_radix_digits_core_test.sv
